@@ src/audio_leveler_agc_clip_core_assert.svh @@
// Assertion macros shared by the leveler RTL; define ASSERT_OFF to drop them.
`ifndef AUDIO_LEVELER_AGC_CLIP_CORE_ASSERT_SVH
`define AUDIO_LEVELER_AGC_CLIP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, clocked on clk, off during reset.
`define ALAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("leveler check failed");
// Next-cycle implication, clocked on clk, off during reset.
`define ALAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("leveler check failed");
`else
`define ALAC_ASSERT_IMP(lbl, ante, cons)
`define ALAC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/alac_pkg.sv @@
package alac_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int GAIN_W     = 16;
    localparam int COEFF_W    = 24;
    localparam int ENV_W      = 32;
    localparam int PCM_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // Floor register is Q0.24, envelope is Q1.31
    localparam int FLOOR_SHIFT = 7;
    // Exponent of the fixed quotient scale (0.5 * Q4.12 * 32767 vs. Q1.31)
    localparam int QUOT_SCALE_EXP = 19;

    localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd4096;
    localparam logic [COEFF_W-1:0] ATTACK_RST = 24'd16777;
    localparam logic [COEFF_W-1:0] DECAY_RST  = 24'd336;
    localparam logic [COEFF_W-1:0] FLOOR_RST  = 24'd83886;
    localparam logic [ENV_W-1:0]   ENV_RST    = 32'd21474836;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_GAIN   = 8'd0;
    localparam cfg_idx_t CFG_ATTACK = 8'd1;
    localparam cfg_idx_t CFG_DECAY  = 8'd2;
    localparam cfg_idx_t CFG_FLOOR  = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMMIT,
        ST_DLOAD,
        ST_DIV,
        ST_FIN
    } alac_state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } alac_ctl_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic commit;
    } alac_env_ctl_t;

endpackage

@@ src/alac_sample_if.sv @@
interface alac_sample_if #(
    parameter int W = alac_pkg::SAMPLE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink   (input valid, input audio_sample, output ready);
endinterface

@@ src/alac_pcm_if.sv @@
interface alac_pcm_if;
    logic                              valid;
    logic                              ready;
    logic signed [alac_pkg::PCM_W-1:0] pcm_out;

    modport source (output valid, output pcm_out, input ready);
    modport sink   (input valid, input pcm_out, output ready);
endinterface

@@ src/alac_cfg_if.sv @@
interface alac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [alac_pkg::CFG_IDX_W-1:0]  index;
    logic [alac_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/alac_env.sv @@
module alac_env #(
    parameter int SAMPLE_WIDTH = alac_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  alac_pkg::alac_env_ctl_t         ctl,
    input  logic [SAMPLE_WIDTH-1:0]         mag,
    input  logic [alac_pkg::COEFF_W-1:0]    attack,
    input  logic [alac_pkg::COEFF_W-1:0]    decay,
    output logic [alac_pkg::ENV_W-1:0]      env
);
    import alac_pkg::*;

    logic [ENV_W-1:0]          env_reg, env_next;
    logic [COEFF_W-1:0]        coef_reg, coef_next;
    logic signed [ENV_W:0]     diff_reg, diff_next;
    logic signed [ENV_W:0]     acc_reg, acc_next;
    logic [ENV_W-1:0]          lvl;
    logic signed [ENV_W+1:0]   acc_sum;
    logic signed [ENV_W+1:0]   env_sum;

    // Rectified level in Q1.31 and signed distance to the envelope
    assign lvl       = ENV_W'(mag) << (ENV_W - SAMPLE_WIDTH);
    assign diff_next = $signed({1'b0, lvl}) - $signed({1'b0, env_reg});

    // One coefficient bit per cycle, LSB first; arithmetic shift keeps floor
    assign acc_sum = coef_reg[0] ? ({acc_reg[ENV_W], acc_reg} + {diff_reg[ENV_W], diff_reg})
                                 : {acc_reg[ENV_W], acc_reg};
    assign env_sum = $signed({2'b00, env_reg}) + $signed({acc_reg[ENV_W], acc_reg});

    always_comb
    begin
        coef_next = coef_reg;
        acc_next  = acc_reg;
        env_next  = env_reg;
        if (ctl.load)
        begin
            coef_next = (lvl > env_reg) ? attack : decay;
            acc_next  = '0;
        end
        else if (ctl.shift)
        begin
            coef_next = coef_reg >> 1;
            acc_next  = acc_sum[ENV_W+1:1];
        end
        if (ctl.commit)
        begin
            env_next = env_sum[ENV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg <= ENV_RST;
        end
        else
        begin
            env_reg <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
        if (ctl.load)
        begin
            diff_reg <= diff_next;
        end
    end

    assign env = env_reg;

endmodule

@@ src/alac_mul.sv @@
module alac_mul #(
    parameter int SAMPLE_WIDTH = alac_pkg::SAMPLE_WIDTH_DEF,
    parameter int UP           = 3,
    parameter int NUM_W        = 49
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  alac_pkg::alac_ctl_t          ctl,
    input  logic [SAMPLE_WIDTH-1:0]      mag,
    input  logic [alac_pkg::GAIN_W-1:0]  gain,
    output logic [NUM_W-1:0]             num
);
    import alac_pkg::*;

    localparam int FS = PCM_W - 1;
    localparam int PW = SAMPLE_WIDTH + GAIN_W;

    logic [SAMPLE_WIDTH-1:0] mcand_reg, mcand_next;
    logic [SAMPLE_WIDTH-1:0] hi_reg, hi_next;
    logic [GAIN_W-1:0]       lo_reg, lo_next;
    logic [SAMPLE_WIDTH:0]   sum;
    logic [PW-1:0]           prod;
    logic [PW+FS-1:0]        scaled;

    // Shift-add over the gain bits; product low bits fill the gain register
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (ctl.load)
        begin
            mcand_next = mag;
            hi_next    = '0;
            lo_next    = gain;
        end
        else if (ctl.shift)
        begin
            hi_next = sum[SAMPLE_WIDTH:1];
            lo_next = {sum[0], lo_reg[GAIN_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
        end
        else
        begin
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        lo_reg    <= lo_next;
    end

    // Times full-scale PCM (2^15 - 1), then align to the divisor
    assign prod   = {hi_reg, lo_reg};
    assign scaled = {prod, {FS{1'b0}}} - (PW + FS)'(prod);
    assign num    = NUM_W'(scaled) << UP;

endmodule

@@ src/alac_div.sv @@
module alac_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  alac_pkg::alac_ctl_t          ctl,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output logic [alac_pkg::PCM_W-2:0]   quo
);
    import alac_pkg::*;

    localparam int QW = PCM_W;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]    q_reg, q_next;
    logic             ge;

    // Restoring division, one quotient bit per cycle, MSB first.
    // The top bit flags a quotient beyond full scale.
    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        if (ctl.load)
        begin
            rem_next = num;
            dsh_next = NUM_W'(den) << (QW - 1);
            q_next   = '0;
        end
        else if (ctl.shift)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
    end

    // Saturate at full scale
    assign quo = q_reg[QW-1] ? '1 : q_reg[QW-2:0];

endmodule

@@ src/audio_leveler_agc_clip_core.sv @@
// Each sample passes the 24-step bit-serial envelope multiply and then the 16-step
// restoring divider, which run one after the other. A new sample is taken only once the
// last result is in the output register; that move waits while the register is full.
// Reset (rst_n, asynchronous, active low): idle, no result pending, registers
// back to their defaults and the envelope back to 0.01.
`include "audio_leveler_agc_clip_core_assert.svh"

module audio_leveler_agc_clip_core #(
    parameter int SAMPLE_WIDTH = alac_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    alac_cfg_if.sink      cfg,
    alac_sample_if.sink   sample,
    alac_pcm_if.source    result
);
    import alac_pkg::*;

    // Quotient alignment: numerator scaled up for narrow samples, divisor for wide ones
    localparam int UP    = (SAMPLE_WIDTH <= QUOT_SCALE_EXP) ? QUOT_SCALE_EXP - SAMPLE_WIDTH : 0;
    localparam int DN    = (SAMPLE_WIDTH > QUOT_SCALE_EXP) ? SAMPLE_WIDTH - QUOT_SCALE_EXP : 0;
    localparam int NUM_W = SAMPLE_WIDTH + 30 + UP;
    localparam int DEN_W = ENV_W + DN;
    localparam int CNT_W = $clog2(COEFF_W);

    // ------------------------------------------------------------------
    // Configuration registers; the write port is always ready.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  gain_reg, gain_next;
    logic [COEFF_W-1:0] attack_reg, attack_next;
    logic [COEFF_W-1:0] decay_reg, decay_next;
    logic [COEFF_W-1:0] floor_reg, floor_next;
    logic               cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_comb
    begin
        gain_next   = gain_reg;
        attack_next = attack_reg;
        decay_next  = decay_reg;
        floor_next  = floor_reg;
        if (cfg_we)
        begin
            // Drop writes to unknown indexes
            case (cfg.index)
                CFG_GAIN:   gain_next   = cfg.data[GAIN_W-1:0];
                CFG_ATTACK: attack_next = cfg.data[COEFF_W-1:0];
                CFG_DECAY:  decay_next  = cfg.data[COEFF_W-1:0];
                CFG_FLOOR:  floor_next  = cfg.data[COEFF_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RST;
            attack_reg <= ATTACK_RST;
            decay_reg  <= DECAY_RST;
            floor_reg  <= FLOOR_RST;
        end
        else
        begin
            gain_reg   <= gain_next;
            attack_reg <= attack_next;
            decay_reg  <= decay_next;
            floor_reg  <= floor_next;
        end
    end

    // ------------------------------------------------------------------
    // Input capture: sign and magnitude of the sample. The most negative
    // code maps to magnitude 2^(SAMPLE_WIDTH-1), i.e. exactly 1.0.
    // ------------------------------------------------------------------
    logic [SAMPLE_WIDTH-1:0] raw_u;
    logic [SAMPLE_WIDTH-1:0] mag_in;
    logic                    in_xfer;
    logic                    neg_reg;

    assign raw_u   = sample.audio_sample;
    assign mag_in  = raw_u[SAMPLE_WIDTH-1]
                   ? ((~raw_u) + {{(SAMPLE_WIDTH-1){1'b0}}, 1'b1}) : raw_u;
    assign in_xfer = sample.valid && sample.ready;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            neg_reg <= raw_u[SAMPLE_WIDTH-1];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    //   IDLE   : wait for a sample transfer, load both serial multipliers
    //   MUL    : 24 envelope steps; the gain product finishes in the first 16
    //   COMMIT : write the new envelope
    //   DLOAD  : form the floored divisor, load the divider
    //   DIV    : 16 quotient bits
    //   FIN    : hand the result to the output register once it is free
    // ------------------------------------------------------------------
    alac_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_load;
    logic               out_valid_reg, out_valid_next;
    logic [PCM_W-1:0]   pcm_reg;
    logic [PCM_W-1:0]   pcm_next;
    alac_env_ctl_t      env_ctl;
    alac_ctl_t          mul_ctl;
    alac_ctl_t          div_ctl;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(COEFF_W - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: state_next = ST_DLOAD;
            ST_DLOAD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(PCM_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Step counter restarts on every state change
    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;

    always_comb
    begin
        sample.ready   = 1'b0;
        env_ctl        = '0;
        mul_ctl        = '0;
        div_ctl        = '0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                env_ctl.load = sample.valid;
                mul_ctl.load = sample.valid;
            end
            ST_MUL:
            begin
                env_ctl.shift = 1'b1;
                mul_ctl.shift = (cnt_reg < CNT_W'(GAIN_W));
            end
            ST_COMMIT: env_ctl.commit = 1'b1;
            ST_DLOAD:  div_ctl.load   = 1'b1;
            ST_DIV:    div_ctl.shift  = 1'b1;
            ST_FIN:    out_load       = !out_valid_reg || result.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath units
    // ------------------------------------------------------------------
    logic [ENV_W-1:0]   env_q;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic [PCM_W-2:0]   quo;
    logic [ENV_W-1:0]   floor_q31;
    logic [ENV_W-1:0]   div_d;

    alac_env #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_env (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (env_ctl),
        .mag    (mag_in),
        .attack (attack_reg),
        .decay  (decay_reg),
        .env    (env_q)
    );

    alac_mul #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .UP           (UP),
        .NUM_W        (NUM_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .mag   (mag_in),
        .gain  (gain_reg),
        .num   (num)
    );

    // Divisor: envelope floored at the configured minimum, never zero
    assign floor_q31 = ENV_W'(floor_reg) << FLOOR_SHIFT;

    always_comb
    begin
        div_d = (env_q > floor_q31) ? env_q : floor_q31;
        if (div_d == '0)
        begin
            div_d = {{(ENV_W-1){1'b0}}, 1'b1};
        end
    end

    assign den = DEN_W'(div_d) << DN;

    alac_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (num),
        .den   (den),
        .quo   (quo)
    );

    // ------------------------------------------------------------------
    // Output register: holds a finished result until its transfer, while
    // the next sample is already taken in.
    // ------------------------------------------------------------------
    assign pcm_next = neg_reg ? ((~{1'b0, quo}) + {{(PCM_W-1){1'b0}}, 1'b1}) : {1'b0, quo};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pcm_reg <= pcm_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.pcm_out = pcm_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ALAC_ASSERT_NXT(a_start_mul, in_xfer, (state_reg == ST_MUL) && (cnt_reg == '0))
    `ALAC_ASSERT_IMP(a_mul_bound, state_reg == ST_MUL, cnt_reg <= CNT_W'(COEFF_W - 1))
    `ALAC_ASSERT_IMP(a_pcm_sym, out_valid_reg, pcm_reg != {1'b1, {(PCM_W-1){1'b0}}})
    `ALAC_ASSERT_NXT(a_fin_hold, (state_reg == ST_FIN) && out_valid_reg && !result.ready,
                     state_reg == ST_FIN)

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alac_pkg::*;

    // Sample width under test; the level predictor below assumes it stays <= 19.
    localparam int SW = SAMPLE_WIDTH_DEF;

    localparam longint unsigned PCM_MAX  = 64'd32767;
    localparam longint unsigned ONE_Q24  = 64'd1 << COEFF_W;

    // Wait after the last result before touching registers or ending the run.
    localparam int DRAIN_CYCLES = 60;
    // Long receiver hold-off used to back the core up into its input.
    localparam int HOLD_CYCLES  = 600;
    // Hard stop, far beyond the slowest legal run.
    localparam int TIMEOUT_NS   = 5_000_000;
    // Errors printed in full; later ones are only counted.
    localparam int MAX_REPORTS  = 10;

    // Register indexes that decode to nothing.
    localparam cfg_idx_t CFG_UNUSED_LO = 8'd4;
    localparam cfg_idx_t CFG_UNUSED_HI = 8'hFF;

    logic clk = 1'b0;
    logic rst_n;

    alac_cfg_if              cfg_ch ();
    alac_sample_if #(.W(SW)) smp_ch ();
    alac_pcm_if              pcm_ch ();

    audio_leveler_agc_clip_core #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (smp_ch),
        .result (pcm_ch)
    );

    // 10 ns clock: high half, then low half.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Leveler predictor: register shadows and envelope state, kept in step
    // with every accepted register write and sample transfer.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  gain_q;
    logic [COEFF_W-1:0] attack_q;
    logic [COEFF_W-1:0] decay_q;
    logic [COEFF_W-1:0] floor_q;
    logic [ENV_W-1:0]   envelope_q;

    // Expected PCM samples, oldest first.
    logic signed [PCM_W-1:0] pcm_expect_q[$];

    int sent_count     = 0;
    int checked_count  = 0;
    int fail_count     = 0;
    int settings_count = 0;
    int saturated_count = 0;

    // Idle knobs, read by the sender task and the receiver process.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    // Long hold-off request; the receiver process owns the countdown.
    logic hold_req = 1'b0;
    int   hold_left = 0;

    function automatic void reset_leveler();
        gain_q     = GAIN_RST;
        attack_q   = ATTACK_RST;
        decay_q    = DECAY_RST;
        floor_q    = FLOOR_RST;
        envelope_q = ENV_RST;
    endfunction

    // Advance the envelope by one sample and return the leveled PCM value.
    function automatic logic signed [PCM_W-1:0] level_sample(input logic signed [SW-1:0] s);
        logic            neg;
        longint unsigned raw, mag, lvl, env, wt, fl, dvs, num, quo;
        logic [PCM_W-1:0] q16;

        neg = s[SW-1];
        raw = 64'($unsigned(s));
        // The most negative sample has magnitude exactly 1.0.
        mag = neg ? ((64'd1 << SW) - raw) : raw;

        // Asymmetric smoothing: attack weight only when the level rises.
        lvl = mag << (ENV_W - SW);
        env = 64'(envelope_q);
        wt  = (lvl > env) ? 64'(attack_q) : 64'(decay_q);
        env = (wt * lvl + (ONE_Q24 - wt) * env) >> COEFF_W;
        envelope_q = env[ENV_W-1:0];

        // Divisor is floored; a zero divisor is taken as one LSB.
        fl  = 64'(floor_q) << FLOOR_SHIFT;
        dvs = (env > fl) ? env : fl;
        if (dvs == 0)
            dvs = 1;

        num = (mag * 64'(gain_q) * PCM_MAX) << (QUOT_SCALE_EXP - SW);
        quo = num / dvs;
        if (quo > PCM_MAX)
        begin
            quo = PCM_MAX;
            saturated_count++;
        end

        q16 = quo[PCM_W-1:0];
        return neg ? -$signed(q16) : $signed(q16);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pcm_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            // Start the hold-off on this cycle and drop the request.
            pcm_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_req <= 1'b0;
        end
        else
            pcm_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: each PCM transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic signed [PCM_W-1:0] want;
        if (rst_n && pcm_ch.valid && pcm_ch.ready)
        begin
            if (pcm_expect_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: pcm_out=%0d", $realtime,
                             pcm_ch.pcm_out);
            end
            else
            begin
                want = pcm_expect_q.pop_front();
                checked_count++;
                if (pcm_ch.pcm_out !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result %0d mismatch: pcm_out expected %0d, got %0d",
                                 $realtime, checked_count, want, pcm_ch.pcm_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks. Each one starts and ends on a falling edge.
    // ------------------------------------------------------------------

    // Offer one sample; valid stays high afterwards so back-to-back samples
    // need no second assignment in one step. Callers drop it when done.
    task automatic send_sample(input logic signed [SW-1:0] s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            smp_ch.audio_sample <= SW'($urandom);
            @(negedge clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.audio_sample <= s;
        do
            @(posedge clk);
        while (!smp_ch.ready);
        pcm_expect_q.push_back(level_sample(s));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic end_samples();
        smp_ch.valid <= 1'b0;
    endtask

    // Write one register; valid stays high for a following write.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_GAIN:   gain_q   = val[GAIN_W-1:0];
            CFG_ATTACK: attack_q = val[COEFF_W-1:0];
            CFG_DECAY:  decay_q  = val[COEFF_W-1:0];
            CFG_FLOOR:  floor_q  = val[COEFF_W-1:0];
            default:    ;
        endcase
        @(negedge clk);
    endtask

    // Wait until every expected result is in, then let the core go quiet.
    task automatic settle();
        while (pcm_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] gain,
                                  input logic [CFG_DATA_W-1:0] attack,
                                  input logic [CFG_DATA_W-1:0] decay,
                                  input logic [CFG_DATA_W-1:0] flr);
        settle();
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_ATTACK, attack);
        write_reg(CFG_DECAY, decay);
        write_reg(CFG_FLOOR, flr);
        cfg_ch.valid <= 1'b0;
        settings_count++;
    endtask

    // Random register set, one of four equally likely kinds: audio-like weights, wider
    // ranges, anything at all, or the extremes.
    task automatic apply_random_settings();
        logic [CFG_DATA_W-1:0] g, a, d, f;
        case ($urandom_range(3))
            0:
            begin
                g = CFG_DATA_W'($urandom_range(8192, 1024));
                a = CFG_DATA_W'($urandom_range(1 << 18, 1 << 10));
                d = CFG_DATA_W'($urandom_range(1 << 12, 1));
                f = CFG_DATA_W'($urandom_range(1 << 18, 1 << 12));
            end
            1:
            begin
                g = CFG_DATA_W'($urandom);
                a = CFG_DATA_W'($urandom);
                d = CFG_DATA_W'($urandom);
                f = CFG_DATA_W'($urandom);
            end
            2:
            begin
                g = CFG_DATA_W'($urandom_range(65535));
                a = CFG_DATA_W'($urandom_range(1 << 23, 1 << 16));
                d = CFG_DATA_W'($urandom_range(1 << 20, 1 << 8));
                f = $urandom_range(3) == 0 ? '0 : CFG_DATA_W'($urandom_range(1 << 16));
            end
            default:
            begin
                g = $urandom_range(1) ? 24'h00FFFF : CFG_DATA_W'($urandom_range(65535));
                a = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                d = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                f = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            end
        endcase
        apply_settings(g, a, d, f);
    endtask

    // Sample mix: full-scale noise, quiet passages of random depth, extremes.
    function automatic logic signed [SW-1:0] pick_sample();
        int          k;
        logic [SW-1:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(5))
                    0: v = {1'b1, {(SW-1){1'b0}}};
                    1: v = {1'b0, {(SW-1){1'b1}}};
                    2: v = '0;
                    3: v = SW'(1);
                    4: v = '1;
                    default: v = {1'b1, {(SW-2){1'b0}}, 1'b1};
                endcase
            end
            1, 2, 3, 4: v = SW'($urandom);
            default:
            begin
                k = $urandom_range(SW - 1, 1);
                v = SW'($urandom_range((1 << k) - 1));
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return $signed(v);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: unity gain, default weights and floor, envelope at 0.01.
    task automatic test_reset_defaults();
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        end_samples();
    endtask

    // All registers at their maximum: envelope jumps almost straight to the level.
    task automatic test_register_max();
        apply_settings(24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        end_samples();
    endtask

    // Zero floor with the envelope decayed to nothing: divisor becomes one LSB.
    task automatic test_zero_divisor();
        apply_settings(24'd4096, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
        // Two silent samples pull the envelope down to zero.
        send_sample(16'sd0);
        send_sample(16'sd0);
        end_samples();
        // Zero attack weight keeps the envelope at zero on loud samples.
        apply_settings(24'd4096, 24'd0, 24'hFFFFFF, 24'd0);
        send_sample(16'sd1);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        end_samples();
        // Zero gain: output is zero even with a one-LSB divisor.
        apply_settings(24'd0, 24'd0, 24'hFFFFFF, 24'd0);
        send_sample(-16'sd5);
        end_samples();
    endtask

    // Gain bits above 16 are dropped; unknown register indexes do nothing.
    task automatic test_register_decode();
        settle();
        write_reg(CFG_GAIN, 24'h5A2000);
        write_reg(CFG_UNUSED_LO, 24'hFFFFFF);
        write_reg(CFG_UNUSED_HI, 24'h000000);
        write_reg(CFG_ATTACK, 24'h0A0000);
        write_reg(CFG_DECAY, 24'h000400);
        write_reg(CFG_FLOOR, 24'h020000);
        cfg_ch.valid <= 1'b0;
        settings_count++;
        send_sample(16'sd12000);
        send_sample(-16'sd700);
        end_samples();
    endtask

    // Hold the output off for a long stretch while samples keep coming,
    // so the core backs up and stalls its input.
    task automatic test_backpressure();
        apply_random_settings();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req <= 1'b1;
        repeat (10) send_sample(pick_sample());
        end_samples();
    endtask

    // Random samples under one idle pattern, two register sets per phase.
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (2)
        begin
            apply_random_settings();
            repeat (n / 2) send_sample(pick_sample());
            end_samples();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Quiet, known inputs from time zero, with reset asserted.
        rst_n               = 1'b0;
        smp_ch.valid        = 1'b0;
        smp_ch.audio_sample = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_GAIN;
        cfg_ch.data         = '0;
        pcm_ch.ready        = 1'b0;
        reset_leveler();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_register_max();
        test_zero_divisor();
        test_register_decode();

        test_random_phase(0, 0, 120);
        test_backpressure();
        test_random_phase(84, 0, 120);
        test_random_phase(0, 84, 120);
        test_random_phase(36, 36, 120);

        // Drain and let the core fall quiet before judging the run.
        settle();
        if (pcm_expect_q.size() != 0)
            fail_count++;

        $display("Run covered %0d samples under %0d register settings across four idle patterns",
                 sent_count, settings_count);
        $display("and one long output hold-off; %0d results checked, %0d saturated, %0d errors",
                 checked_count, saturated_count, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still outstanding", pcm_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/alac_pkg.sv
src/alac_sample_if.sv
src/alac_pcm_if.sv
src/alac_cfg_if.sv
src/alac_env.sv
src/alac_mul.sv
src/alac_div.sv
src/audio_leveler_agc_clip_core.sv
dv/tb_top.sv
